// ===== src/rvp_pkg.sv =====
// rvp_pkg: shared types, constants and helper functions of the radial vignette pixel pipeline
// no dependencies
package rvp_pkg;

  localparam int unsigned SQ_STEPS  = 24;   // deepest digit-step count of the root
  localparam int unsigned SQ_STEP_LO = 5;
  localparam int unsigned SQ_W      = 32;   // root and remainder width
  localparam int unsigned DIV_BITS  = 8;    // quotient bits of the gain division
  localparam int unsigned DIV_W     = 40;   // numerator width of the gain division
  localparam logic [7:0]  GAIN_MAX  = 8'd255;
  localparam logic [7:0]  GAIN_DROP = 8'd165;

  typedef logic [SQ_W-1:0] sq_t;

  typedef struct packed {
    sq_t rem;
    sq_t root;
  } sq_pair_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pix_t;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_STEPS  = 2'd2,
    REG_NONE   = 2'd3
  } reg_addr_e;

  // trial bit of digit step i, zero once past the lowest bit pair
  function automatic sq_t sq_bit(input int unsigned i);
    sq_t b;
    b = '0;
    if (i <= 15) begin
      b = sq_t'(32'h4000_0000 >> (2 * i));
    end
    return b;
  endfunction

  function automatic sq_pair_t sq_step(input sq_pair_t a, input sq_t b);
    sq_pair_t r;
    r = a;
    if (b + a.root <= a.rem) begin
      r.rem  = a.rem - (b + a.root);
      r.root = (a.root >> 1) | b;
    end else begin
      r.root = a.root >> 1;
    end
    return r;
  endfunction

  // contrast map clamp(2t - 64) for t in 0..255
  function automatic logic [7:0] contrast(input logic [7:0] t);
    logic [7:0] v;
    if (t < 8'd32) begin
      v = 8'd0;
    end else if (t >= 8'd160) begin
      v = 8'd255;
    end else begin
      v = 8'({t, 1'b0} - 9'd64);
    end
    return v;
  endfunction

  // exact floor(x / 255) for x up to 65279, where the quotient fits in 8 bits
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = 17'(x) + 17'(x >> 8) + 17'd1;
    return s[15:8];
  endfunction

endpackage

// ===== src/radial_vignette_pixel.sv =====
// radial_vignette_pixel: top level of the radial vignette and contrast pipeline
// depends on rvp_pkg
//
// usage
//  - input channel: in_valid_i with col, row and rgba; a word is taken at a rising edge
//    with in_valid_i high and in_stall_o low
//  - output channel: out_valid_o with rgb, alpha and radius_zero; the receiver holds
//    out_stall_i high to keep the word on the ports
//  - config: apb-style port, width at 0x0, height at 0x4, root step count at 0x8;
//    write only while no word is in flight
//  - throughput: one word per cycle while the output is not stalled, every stage moves at once
//  - pipeline: 39 register stages between the input port and the output ports:
//    two front stages (centre offset, squares), 24 digit stages of the two roots,
//    a rounding stage, the 165*r product, eight restoring quotient stages, the gain stage,
//    the channel products and the output register
//  - the longest stage is one root digit step (a 32-bit add, compare and subtract)
//  - stall: while the output word waits under out_stall_i the whole pipe holds and
//    in_stall_o is raised; nothing is dropped or repeated
//  - reset: all valid bits cleared, registers back to 1024 x 1024 and 16 root steps
module radial_vignette_pixel #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input words
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [11:0] col_i,
  input  logic [11:0] row_i,
  input  logic [7:0]  red_in_i,
  input  logic [7:0]  green_in_i,
  input  logic [7:0]  blue_in_i,
  input  logic [7:0]  alpha_in_i,
  // output words
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  red_out_o,
  output logic [7:0]  green_out_o,
  output logic [7:0]  blue_out_o,
  output logic [7:0]  alpha_out_o,
  output logic        radius_zero_o
);

  localparam int unsigned NS = rvp_pkg::SQ_STEPS;
  localparam int unsigned ND = rvp_pkg::DIV_BITS;
  localparam int unsigned DW = rvp_pkg::DIV_W;

  // ---------------------------------------------------------------- config registers
  logic [12:0] width_q, height_q;
  logic [4:0]  steps_q;
  rvp_pkg::reg_addr_e addr;

  assign addr   = rvp_pkg::reg_addr_e'(paddr[3:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 13'd1024;
      height_q <= 13'd1024;
      steps_q  <= 5'd16;
    end else if (psel && penable && pwrite) begin
      unique case (addr)
        rvp_pkg::REG_WIDTH:  width_q  <= pwdata[12:0];
        rvp_pkg::REG_HEIGHT: height_q <= pwdata[12:0];
        rvp_pkg::REG_STEPS:  steps_q  <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (addr)
      rvp_pkg::REG_WIDTH:  prdata = {19'd0, width_q};
      rvp_pkg::REG_HEIGHT: prdata = {19'd0, height_q};
      rvp_pkg::REG_STEPS:  prdata = {27'd0, steps_q};
      default:             prdata = '0;
    endcase
  end

  // saturated views of the registers
  logic [12:0] w_sat, h_sat;
  logic [4:0]  s_sat;
  assign w_sat = (32'(width_q)  > MAX_DIM) ? 13'(MAX_DIM) : width_q;
  assign h_sat = (32'(height_q) > MAX_DIM) ? 13'(MAX_DIM) : height_q;
  assign s_sat = (steps_q < 5'(rvp_pkg::SQ_STEP_LO)) ? 5'(rvp_pkg::SQ_STEP_LO) :
                 (steps_q > 5'(NS)) ? 5'(NS) : steps_q;

  // global advance: the whole pipe holds while the output word is stalled
  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // ---------------------------------------------------------------- stage a: centre offset
  logic              a_v_q;
  logic signed [12:0] a_dx_q, a_dy_q;
  logic [12:0]       a_w_q, a_h_q;
  rvp_pkg::pix_t     a_pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) a_v_q <= 1'b0;
    else if (en) a_v_q <= in_valid_i;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      a_dx_q  <= $signed({1'b0, col_i}) - $signed({1'b0, w_sat[12:1]});
      a_dy_q  <= $signed({1'b0, row_i}) - $signed({1'b0, h_sat[12:1]});
      a_w_q   <= w_sat;
      a_h_q   <= h_sat;
      a_pix_q <= '{red: red_in_i, green: green_in_i, blue: blue_in_i, alpha: alpha_in_i};
    end
  end

  // ---------------------------------------------------------------- stage b: squares
  logic signed [25:0] dx2, dy2;
  logic [25:0]        w2, h2;
  logic               b_v_q;
  rvp_pkg::sq_t       b_d2_q, b_m2_q;
  rvp_pkg::pix_t      b_pix_q;

  assign dx2 = a_dx_q * a_dx_q;
  assign dy2 = a_dy_q * a_dy_q;
  assign w2  = 26'(a_w_q * a_w_q);
  assign h2  = 26'(a_h_q * a_h_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) b_v_q <= 1'b0;
    else if (en) b_v_q <= a_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      b_d2_q  <= 32'($unsigned(dx2)) + 32'($unsigned(dy2));
      b_m2_q  <= 32'(w2) + 32'(h2);
      b_pix_q <= a_pix_q;
    end
  end

  // ---------------------------------------------------------------- root digit stages
  // both roots (pixel distance and frame diagonal) step side by side
  logic               s_v_q   [NS];
  rvp_pkg::sq_pair_t  s_d_q   [NS];
  rvp_pkg::sq_pair_t  s_m_q   [NS];
  rvp_pkg::pix_t      s_pix_q [NS];

  for (genvar g = 0; g < NS; g++) begin : g_sq
    localparam rvp_pkg::sq_t BIT = rvp_pkg::sq_bit(g);
    logic              v_in;
    rvp_pkg::sq_pair_t d_in, m_in;
    rvp_pkg::pix_t     p_in;
    logic              act;

    if (g == 0) begin : g_first
      assign v_in = b_v_q;
      assign d_in = '{rem: b_d2_q, root: '0};
      assign m_in = '{rem: b_m2_q, root: '0};
      assign p_in = b_pix_q;
    end else begin : g_next
      assign v_in = s_v_q[g-1];
      assign d_in = s_d_q[g-1];
      assign m_in = s_m_q[g-1];
      assign p_in = s_pix_q[g-1];
    end

    assign act = (5'(g) < s_sat);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) s_v_q[g] <= 1'b0;
      else if (en) s_v_q[g] <= v_in;
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        s_d_q[g]   <= act ? rvp_pkg::sq_step(d_in, BIT) : d_in;
        s_m_q[g]   <= act ? rvp_pkg::sq_step(m_in, BIT) : m_in;
        s_pix_q[g] <= p_in;
      end
    end
  end

  // ---------------------------------------------------------------- stage f: rounding
  rvp_pkg::sq_pair_t d_last, m_last;
  rvp_pkg::sq_t      r_rnd, m_rnd;
  logic              f_v_q, f_zero_q;
  rvp_pkg::sq_t      f_r_q, f_m_q;
  rvp_pkg::pix_t     f_pix_q;

  assign d_last = s_d_q[NS-1];
  assign m_last = s_m_q[NS-1];
  assign r_rnd  = d_last.root + rvp_pkg::sq_t'(d_last.root < d_last.rem);
  assign m_rnd  = (m_last.root + rvp_pkg::sq_t'(m_last.root < m_last.rem)) >> 1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) f_v_q <= 1'b0;
    else if (en) f_v_q <= s_v_q[NS-1];
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      f_r_q    <= r_rnd;
      f_m_q    <= m_rnd;
      f_zero_q <= (m_rnd == '0);
      f_pix_q  <= s_pix_q[NS-1];
    end
  end

  // ---------------------------------------------------------------- stage n: 165 * r
  logic          n_v_q, n_zero_q;
  logic [DW-1:0] n_num_q, n_den_q;
  rvp_pkg::pix_t n_pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) n_v_q <= 1'b0;
    else if (en) n_v_q <= f_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      n_num_q  <= DW'(f_r_q) * DW'(rvp_pkg::GAIN_DROP);
      n_den_q  <= DW'(f_m_q);
      n_zero_q <= f_zero_q;
      n_pix_q  <= f_pix_q;
    end
  end

  // ---------------------------------------------------------------- quotient stages
  // restoring division, one quotient bit per stage, msb first; a quotient of 256 or
  // more is flagged up front and drives the gain to zero unless the radius is zero
  logic          q_v_q    [ND];
  logic          q_sat_q  [ND];
  logic          q_zero_q [ND];
  logic [DW-1:0] q_rem_q  [ND];
  logic [DW-1:0] q_den_q  [ND];
  logic [7:0]    q_quo_q  [ND];
  rvp_pkg::pix_t q_pix_q  [ND];

  for (genvar k = 0; k < ND; k++) begin : g_div
    localparam int unsigned SH = ND - 1 - k;
    logic          v_in, sat_in, zero_in;
    logic [DW-1:0] rem_in, den_in, trial;
    logic [7:0]    quo_in;
    rvp_pkg::pix_t p_in;
    logic          take;

    if (k == 0) begin : g_first
      assign v_in    = n_v_q;
      assign sat_in  = (n_num_q >= (n_den_q << ND));
      assign zero_in = n_zero_q;
      assign rem_in  = n_num_q;
      assign den_in  = n_den_q;
      assign quo_in  = '0;
      assign p_in    = n_pix_q;
    end else begin : g_next
      assign v_in    = q_v_q[k-1];
      assign sat_in  = q_sat_q[k-1];
      assign zero_in = q_zero_q[k-1];
      assign rem_in  = q_rem_q[k-1];
      assign den_in  = q_den_q[k-1];
      assign quo_in  = q_quo_q[k-1];
      assign p_in    = q_pix_q[k-1];
    end

    assign trial = den_in << SH;
    assign take  = (rem_in >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) q_v_q[k] <= 1'b0;
      else if (en) q_v_q[k] <= v_in;
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        q_rem_q[k]  <= take ? rem_in - trial : rem_in;
        q_quo_q[k]  <= quo_in | (take ? 8'(1 << SH) : 8'd0);
        q_sat_q[k]  <= sat_in;
        q_zero_q[k] <= zero_in;
        q_den_q[k]  <= den_in;
        q_pix_q[k]  <= p_in;
      end
    end
  end

  // ---------------------------------------------------------------- stage c: gain
  logic          c_v_q, c_zero_q;
  logic [7:0]    c_gain_q;
  rvp_pkg::pix_t c_pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) c_v_q <= 1'b0;
    else if (en) c_v_q <= q_v_q[ND-1];
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      if (q_zero_q[ND-1]) begin
        c_gain_q <= rvp_pkg::GAIN_MAX;
      end else if (q_sat_q[ND-1]) begin
        c_gain_q <= 8'd0;
      end else begin
        c_gain_q <= rvp_pkg::GAIN_MAX - q_quo_q[ND-1];
      end
      c_zero_q <= q_zero_q[ND-1];
      c_pix_q  <= q_pix_q[ND-1];
    end
  end

  // ---------------------------------------------------------------- stage p: channel products
  logic          p_v_q, p_zero_q;
  logic [15:0]   p_red_q, p_green_q, p_blue_q;
  logic [7:0]    p_alpha_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) p_v_q <= 1'b0;
    else if (en) p_v_q <= c_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      p_red_q   <= c_pix_q.red   * c_gain_q;
      p_green_q <= c_pix_q.green * c_gain_q;
      p_blue_q  <= c_pix_q.blue  * c_gain_q;
      p_alpha_q <= c_pix_q.alpha;
      p_zero_q  <= c_zero_q;
    end
  end

  // ---------------------------------------------------------------- output register
  // scale by 1/255 and contrast map on the way into the output word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else if (en) out_valid_o <= p_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      red_out_o     <= rvp_pkg::contrast(rvp_pkg::div255(p_red_q));
      green_out_o   <= rvp_pkg::contrast(rvp_pkg::div255(p_green_q));
      blue_out_o    <= rvp_pkg::contrast(rvp_pkg::div255(p_blue_q));
      alpha_out_o   <= p_alpha_q;
      radius_zero_o <= p_zero_q;
    end
  end

  // ---------------------------------------------------------------- assertions
  // a stalled output word holds the input side back
  a_stall_back : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("output stalled but input not held");

  // nothing holds the input while the output is free
  a_no_idle_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_valid_o && out_stall_i) |-> !in_stall_o)
    else $error("input held with output free");

  // a held word is still there next cycle
  a_word_kept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled output word lost");

  // the root step count used stays inside its range
  a_steps_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_sat >= 5'(rvp_pkg::SQ_STEP_LO)) && (s_sat <= 5'(NS)))
    else $error("root step count out of range");

endmodule

// ===== tb/sv/tb_top.sv =====
// tb_top: self-checking bench for radial_vignette_pixel, with a gain predictor in a scoreboard
// depends on rvp_pkg and radial_vignette_pixel
module tb_top;

  localparam longint unsigned MAX_DIM_TB = 4096;
  localparam int LATENCY  = 45;     // pipe depth plus margin
  localparam int WDOG_MAX = 20000;  // idle cycles before giving up

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       rzero;
  } shade_t;

  // scoreboard: own copy of the frame registers, queue of predicted shaded pixels
  class vignette_board;
    logic [12:0] frame_w;
    logic [12:0] frame_h;
    logic [4:0]  root_steps;
    shade_t      pending[$];
    int          errors;

    function new();
      frame_w    = 13'd1024;
      frame_h    = 13'd1024;
      root_steps = 5'd16;
      errors     = 0;
    endfunction

    function void set_reg(rvp_pkg::reg_addr_e idx, logic [31:0] val);
      case (idx)
        rvp_pkg::REG_WIDTH:  frame_w    = val[12:0];
        rvp_pkg::REG_HEIGHT: frame_h    = val[12:0];
        rvp_pkg::REG_STEPS:  root_steps = val[4:0];
        default: ;
      endcase
    endfunction

    // digit-by-digit root, trial bits run out after sixteen steps
    function longint unsigned digit_sqrt(longint unsigned rem, int steps);
      longint unsigned root, b;
      root = 0;
      for (int i = 0; i < steps; i++) begin
        b = (i <= 15) ? (64'h4000_0000 >> (2 * i)) : 64'd0;
        if (b + root <= rem) begin
          rem  = rem - (b + root);
          root = (root >> 1) | b;
        end else begin
          root = root >> 1;
        end
      end
      if (root < rem) root++;
      return root;
    endfunction

    function logic [7:0] boost(longint unsigned t);
      longint v;
      v = 2 * longint'(t) - 64;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return v[7:0];
    endfunction

    function void note_pixel(logic [11:0] col, logic [11:0] row, logic [7:0] red,
                             logic [7:0] green, logic [7:0] blue, logic [7:0] alpha);
      longint unsigned w, h, dist2, maxr, r, drop, gain;
      longint dx, dy;
      int steps;
      shade_t e;
      w     = (frame_w > MAX_DIM_TB) ? MAX_DIM_TB : frame_w;
      h     = (frame_h > MAX_DIM_TB) ? MAX_DIM_TB : frame_h;
      steps = (root_steps < 5) ? 5 : ((root_steps > 24) ? 24 : root_steps);
      dx    = longint'(col) - longint'(w >> 1);
      dy    = longint'(row) - longint'(h >> 1);
      dist2 = dx * dx + dy * dy;
      maxr  = digit_sqrt(w * w + h * h, steps) / 2;
      e.rzero = (maxr == 0);
      if (maxr == 0) begin
        gain = 255;
      end else begin
        r    = digit_sqrt(dist2, steps);
        drop = (165 * r) / maxr;
        gain = (drop >= 255) ? 0 : 255 - drop;
      end
      e.red   = boost((red * gain) / 255);
      e.green = boost((green * gain) / 255);
      e.blue  = boost((blue * gain) / 255);
      e.alpha = alpha;
      pending.push_back(e);
    endfunction

    function void check_pixel(shade_t got);
      shade_t e;
      if (pending.size() == 0) begin
        $error("unexpected output word");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.red !== e.red) begin
        $error("red_out expected %0d got %0d", e.red, got.red); errors++;
      end
      if (got.green !== e.green) begin
        $error("green_out expected %0d got %0d", e.green, got.green); errors++;
      end
      if (got.blue !== e.blue) begin
        $error("blue_out expected %0d got %0d", e.blue, got.blue); errors++;
      end
      if (got.alpha !== e.alpha) begin
        $error("alpha_out expected %0d got %0d", e.alpha, got.alpha); errors++;
      end
      if (got.rzero !== e.rzero) begin
        $error("radius_zero expected %0d got %0d", e.rzero, got.rzero); errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [11:0] col_i = '0, row_i = '0;
  logic [7:0]  red_in_i = '0, green_in_i = '0, blue_in_i = '0, alpha_in_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  red_out_o, green_out_o, blue_out_o, alpha_out_o;
  logic        radius_zero_o;

  vignette_board board;
  bit calm;       // no idling on either side while set
  int quiet_cycles;

  radial_vignette_pixel #(.MAX_DIM(4096)) dut (.*);

  always #5 clk_i = ~clk_i;

  // receiver stalls at random, except in the calm stretch
  always @(negedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 35);
  end

  // watch both channels at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        board.note_pixel(col_i, row_i, red_in_i, green_in_i, blue_in_i, alpha_in_i);
      end
      if (out_valid_o && !out_stall_i) begin
        board.check_pixel('{red_out_o, green_out_o, blue_out_o, alpha_out_o, radius_zero_o});
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WDOG_MAX) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // apb write: setup cycle then access cycle
  task automatic reg_write(rvp_pkg::reg_addr_e idx, logic [31:0] val);
    @(negedge clk_i);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = {idx, 2'b00}; pwdata = val;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    board.set_reg(idx, val);
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  // present one pixel word and hold it until taken
  task automatic send_pixel(logic [11:0] c, logic [11:0] r, logic [7:0] rd,
                            logic [7:0] gr, logic [7:0] bl, logic [7:0] al);
    while (!calm && $urandom_range(99) < 35) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    col_i = c; row_i = r;
    red_in_i = rd; green_in_i = gr; blue_in_i = bl; alpha_in_i = al;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // called at a falling edge right after the last word was taken
  task automatic drain();
    in_valid_i = 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  function automatic logic [7:0] chan_value();
    int k;
    k = $urandom_range(9);
    return (k == 0) ? 8'd0 : (k == 1) ? 8'd255 : 8'($urandom);
  endfunction

  // mostly pixels inside the frame, some anywhere in the index range
  task automatic random_pixels(int n);
    int unsigned w, h;
    logic [11:0] c, r;
    w = (board.frame_w > 4096) ? 4096 : board.frame_w;
    h = (board.frame_h > 4096) ? 4096 : board.frame_h;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 80 && w > 0 && h > 0) begin
        c = 12'($urandom_range(w - 1));
        r = 12'($urandom_range(h - 1));
      end else begin
        c = 12'($urandom);
        r = 12'($urandom);
      end
      send_pixel(c, r, chan_value(), chan_value(), chan_value(), 8'($urandom));
    end
  endtask

  initial begin
    logic [31:0] phase_cfg[9][3];
    board = new();
    calm = 1'b0;
    quiet_cycles = 0;
    phase_cfg = '{'{1024, 1024, 16}, '{4096, 4096, 24}, '{8191, 8191, 31},
                  '{1, 1, 5}, '{0, 0, 0}, '{640, 480, 12}, '{4095, 1, 20},
                  '{3000, 2000, 8}, '{$urandom_range(8191), $urandom_range(8191),
                                    $urandom_range(31)}};
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: corners, centre, channel extremes under the reset frame
    send_pixel(12'd0, 12'd0, 8'd255, 8'd255, 8'd255, 8'd0);
    send_pixel(12'd4095, 12'd4095, 8'd255, 8'd0, 8'd128, 8'd255);
    send_pixel(12'd512, 12'd512, 8'd255, 8'd255, 8'd255, 8'd170);
    send_pixel(12'd512, 12'd512, 8'd0, 8'd0, 8'd0, 8'd85);
    send_pixel(12'd1023, 12'd0, 8'd200, 8'd100, 8'd50, 8'd1);
    send_pixel(12'd0, 12'd1023, 8'd31, 8'd32, 8'd160, 8'd254);
    send_pixel(12'd4095, 12'd0, 8'd255, 8'd255, 8'd255, 8'd127);
    send_pixel(12'd600, 12'd400, 8'd90, 8'd160, 8'd250, 8'd128);
    drain();

    for (int p = 0; p < 9; p++) begin
      reg_write(rvp_pkg::REG_WIDTH, phase_cfg[p][0]);
      reg_write(rvp_pkg::REG_HEIGHT, phase_cfg[p][1]);
      reg_write(rvp_pkg::REG_STEPS, phase_cfg[p][2]);
      calm = (p == 2);  // one long stretch with no idling at all
      random_pixels(94);
      drain();
    end

    if (board.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
